/* rtl/tsd_pkg.sv */
// Shared constants, types and codes of the time sync packet deframer.
package tsd_pkg;

    localparam int BUF_BYTES = 64;
    localparam int NAME_MAX  = 63;
    localparam int BUF_AW    = $clog2(BUF_BYTES);
    localparam int CNT_W     = BUF_AW + 1;
    localparam int EXP_W     = 10;

    localparam logic [7:0] MAGIC_BYTE = 8'hAA;
    localparam logic [7:0] OP_REQUEST = 8'h01;
    localparam logic [7:0] OP_OFFSET  = 8'h03;
    localparam logic [7:0] OP_NAME    = 8'h04;
    localparam logic [7:0] OP_START   = 8'h05;

    localparam int LEN_REQUEST   = 11;
    localparam int LEN_OFFSET    = 10;
    localparam int LEN_NAME_HEAD = 3;
    localparam int LEN_START     = 14;

    typedef enum logic [2:0] {
        KIND_SYNC   = 3'd0,
        KIND_OFFSET = 3'd1,
        KIND_NAME   = 3'd2,
        KIND_REJECT = 3'd3,
        KIND_START  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        RS_IDLE,
        RS_READ,
        RS_CAPTURE,
        RS_EMIT
    } rd_state_t;

    typedef struct packed {
        logic        valid;
        logic [7:0]  op;
        logic [7:0]  len;
        logic [62:0] now;
    } pkt_done_t;

endpackage

/* rtl/tsd_store.sv */
// Packet byte store: one write port, one read port with registered data.
module tsd_store (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [tsd_pkg::BUF_AW-1:0] wr_addr,
    input  logic [7:0]                wr_data,
    input  logic                      rd_en,
    input  logic [tsd_pkg::BUF_AW-1:0] rd_addr,
    output logic [7:0]                rd_data
);
    import tsd_pkg::*;

    logic [7:0] mem [BUF_BYTES];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/tsd_framer.sv */
// Byte hunt and packet length tracking; flags a completed packet.
module tsd_framer (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       accept,
    input  logic [7:0]                 rx_byte,
    input  logic [62:0]                now_us,
    output logic                       wr_en,
    output logic [tsd_pkg::BUF_AW-1:0] wr_addr,
    output logic [7:0]                 wr_data,
    output tsd_pkg::pkt_done_t         done
);
    import tsd_pkg::*;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       op_reg, op_next;
    logic [7:0]       len_reg, len_next;
    logic [CNT_W-1:0] cnt_inc;
    logic [EXP_W-1:0] expected;
    logic             known;
    logic             take;

    always_comb begin
        count_next = count_reg;
        op_next    = op_reg;
        len_next   = len_reg;
        done       = '0;
        done.now   = now_us;
        cnt_inc    = count_reg + CNT_W'(1);
        expected   = '0;
        known      = 1'b1;
        take       = accept && !((count_reg == '0) && (rx_byte != MAGIC_BYTE));
        if (count_reg == CNT_W'(1)) begin
            op_next = rx_byte;
        end
        if (count_reg == CNT_W'(2)) begin
            len_next = rx_byte;
        end
        done.op  = op_next;
        done.len = len_next;
        if (take) begin
            count_next = cnt_inc;
            if (cnt_inc >= CNT_W'(2)) begin
                case (op_next)
                    OP_REQUEST: expected = EXP_W'(LEN_REQUEST);
                    OP_OFFSET:  expected = EXP_W'(LEN_OFFSET);
                    OP_START:   expected = EXP_W'(LEN_START);
                    OP_NAME: begin
                        // length byte not yet in: wait for it
                        if (cnt_inc < CNT_W'(LEN_NAME_HEAD)) begin
                            known = 1'b0;
                        end
                        expected = EXP_W'(LEN_NAME_HEAD) + EXP_W'(len_next);
                    end
                    default: begin
                        known      = 1'b0;
                        count_next = '0;
                    end
                endcase
                if (known) begin
                    if (expected > EXP_W'(BUF_BYTES)) begin
                        count_next = '0;
                    end else if (EXP_W'(cnt_inc) >= expected) begin
                        done.valid = 1'b1;
                        count_next = '0;
                    end
                end
            end
            if (count_next >= CNT_W'(BUF_BYTES)) begin
                count_next = '0;
            end
        end
    end

    assign wr_en   = take;
    assign wr_addr = count_reg[BUF_AW-1:0];
    assign wr_data = rx_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
        op_reg  <= op_next;
        len_reg <= len_next;
    end

endmodule

/* rtl/tsd_readout.sv */
// Readout sequencer: reads a completed packet back and drives result records.
module tsd_readout (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  tsd_pkg::pkt_done_t         done,
    output logic                       idle,
    output logic                       rd_en,
    output logic [tsd_pkg::BUF_AW-1:0] rd_addr,
    input  logic [7:0]                 rd_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [2:0]                 m_kind,
    output logic [7:0]                 m_seq,
    output logic [63:0]                m_value_bits,
    output logic [62:0]                m_device_time,
    output logic [7:0]                 m_sensor_num,
    output logic [7:0]                 m_rate_index,
    output logic [7:0]                 m_storage_opts,
    output logic [7:0]                 m_name_char,
    output logic                       m_last
);
    import tsd_pkg::*;

    rd_state_t         state_reg, state_next;
    logic [BUF_AW-1:0] addr_reg, addr_next;
    logic [BUF_AW-1:0] last_reg, last_next;
    logic [7:0]        op_reg, op_next;
    kind_t             kind_reg, kind_next;
    logic [62:0]       now_reg, now_next;
    logic [7:0]        seq_reg, seq_next;
    logic [63:0]       val_reg, val_next;
    logic [7:0]        sens_reg, sens_next;
    logic [7:0]        rate_reg, rate_next;
    logic [7:0]        stor_reg, stor_next;
    logic [7:0]        char_reg, char_next;

    logic              m_valid_reg, m_valid_next;
    logic [2:0]        m_kind_reg, m_kind_next;
    logic [7:0]        m_seq_reg, m_seq_next;
    logic [63:0]       m_value_reg, m_value_next;
    logic [62:0]       m_dev_reg, m_dev_next;
    logic [7:0]        m_sens_reg, m_sens_next;
    logic [7:0]        m_rate_reg, m_rate_next;
    logic [7:0]        m_stor_reg, m_stor_next;
    logic [7:0]        m_char_reg, m_char_next;
    logic              m_last_reg, m_last_next;

    logic              out_free;
    logic              at_last;
    logic [BUF_AW-1:0] rel;
    kind_t             done_kind;

    assign out_free = !m_valid_reg || m_ready;
    assign at_last  = (addr_reg == last_reg);

    always_comb begin
        case (done.op)
            OP_REQUEST: done_kind = KIND_SYNC;
            OP_OFFSET:  done_kind = KIND_OFFSET;
            OP_START:   done_kind = KIND_START;
            default: begin
                if ((done.len == 8'd0) || (done.len > 8'(NAME_MAX))) begin
                    done_kind = KIND_REJECT;
                end else begin
                    done_kind = KIND_NAME;
                end
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            RS_IDLE: begin
                if (done.valid) begin
                    state_next = (done_kind == KIND_REJECT) ? RS_EMIT : RS_READ;
                end
            end
            RS_READ: state_next = RS_CAPTURE;
            RS_CAPTURE: begin
                if ((kind_reg == KIND_NAME) || at_last) begin
                    state_next = RS_EMIT;
                end else begin
                    state_next = RS_READ;
                end
            end
            RS_EMIT: begin
                if (out_free) begin
                    if ((kind_reg == KIND_NAME) && !at_last) begin
                        state_next = RS_READ;
                    end else begin
                        state_next = RS_IDLE;
                    end
                end
            end
            default: state_next = RS_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        addr_next    = addr_reg;
        last_next    = last_reg;
        op_next      = op_reg;
        kind_next    = kind_reg;
        now_next     = now_reg;
        seq_next     = seq_reg;
        val_next     = val_reg;
        sens_next    = sens_reg;
        rate_next    = rate_reg;
        stor_next    = stor_reg;
        char_next    = char_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_kind_next  = m_kind_reg;
        m_seq_next   = m_seq_reg;
        m_value_next = m_value_reg;
        m_dev_next   = m_dev_reg;
        m_sens_next  = m_sens_reg;
        m_rate_next  = m_rate_reg;
        m_stor_next  = m_stor_reg;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        rd_en        = 1'b0;
        rel          = '0;
        case (state_reg)
            RS_IDLE: begin
                if (done.valid) begin
                    op_next   = done.op;
                    kind_next = done_kind;
                    now_next  = done.now;
                    seq_next  = '0;
                    val_next  = '0;
                    sens_next = '0;
                    rate_next = '0;
                    stor_next = '0;
                    char_next = '0;
                    addr_next = BUF_AW'(2);
                    case (done.op)
                        OP_REQUEST: last_next = BUF_AW'(LEN_REQUEST - 1);
                        OP_OFFSET:  last_next = BUF_AW'(LEN_OFFSET - 1);
                        OP_START:   last_next = BUF_AW'(LEN_START - 1);
                        default: begin
                            addr_next = BUF_AW'(LEN_NAME_HEAD);
                            last_next = BUF_AW'(LEN_NAME_HEAD - 1) + BUF_AW'(done.len);
                        end
                    endcase
                end
            end
            RS_READ: rd_en = 1'b1;
            RS_CAPTURE: begin
                case (op_reg)
                    OP_REQUEST: begin
                        rel = addr_reg - BUF_AW'(3);
                        if (addr_reg == BUF_AW'(2)) begin
                            seq_next = rd_data;
                        end else begin
                            val_next[rel[2:0]*8 +: 8] = rd_data;
                        end
                    end
                    OP_OFFSET: begin
                        rel = addr_reg - BUF_AW'(2);
                        val_next[rel[2:0]*8 +: 8] = rd_data;
                    end
                    OP_START: begin
                        rel = addr_reg - BUF_AW'(6);
                        if (addr_reg == BUF_AW'(2)) begin
                            sens_next = rd_data;
                        end else if (addr_reg == BUF_AW'(3)) begin
                            rate_next = rd_data;
                        end else if (addr_reg == BUF_AW'(4)) begin
                            stor_next = rd_data;
                        end else if (addr_reg != BUF_AW'(5)) begin
                            val_next[rel[2:0]*8 +: 8] = rd_data;
                        end
                    end
                    default: char_next = rd_data;
                endcase
                if ((kind_reg != KIND_NAME) && !at_last) begin
                    addr_next = addr_reg + BUF_AW'(1);
                end
            end
            RS_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = kind_reg;
                    m_seq_next   = seq_reg;
                    m_value_next = val_reg;
                    m_dev_next   = (kind_reg == KIND_SYNC) ? now_reg : '0;
                    m_sens_next  = sens_reg;
                    m_rate_next  = rate_reg;
                    m_stor_next  = stor_reg;
                    m_char_next  = char_reg;
                    m_last_next  = (kind_reg != KIND_NAME) || at_last;
                    if ((kind_reg == KIND_NAME) && !at_last) begin
                        addr_next = addr_reg + BUF_AW'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= RS_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        addr_reg    <= addr_next;
        last_reg    <= last_next;
        op_reg      <= op_next;
        kind_reg    <= kind_next;
        now_reg     <= now_next;
        seq_reg     <= seq_next;
        val_reg     <= val_next;
        sens_reg    <= sens_next;
        rate_reg    <= rate_next;
        stor_reg    <= stor_next;
        char_reg    <= char_next;
        m_kind_reg  <= m_kind_next;
        m_seq_reg   <= m_seq_next;
        m_value_reg <= m_value_next;
        m_dev_reg   <= m_dev_next;
        m_sens_reg  <= m_sens_next;
        m_rate_reg  <= m_rate_next;
        m_stor_reg  <= m_stor_next;
        m_char_reg  <= m_char_next;
        m_last_reg  <= m_last_next;
    end

    assign idle           = (state_reg == RS_IDLE);
    assign rd_addr        = addr_reg;
    assign m_valid        = m_valid_reg;
    assign m_kind         = m_kind_reg;
    assign m_seq          = m_seq_reg;
    assign m_value_bits   = m_value_reg;
    assign m_device_time  = m_dev_reg;
    assign m_sensor_num   = m_sens_reg;
    assign m_rate_index   = m_rate_reg;
    assign m_storage_opts = m_stor_reg;
    assign m_name_char    = m_char_reg;
    assign m_last         = m_last_reg;

endmodule

/* rtl/time_sync_packet_deframer.sv */
// While a packet fills, each accepted byte goes to the store; on completion the packet
// is read back, each byte through the read and capture states, to the output register.
// One byte per cycle is taken outside readout; a name goes out one character per read,
// capture and emit pass, set by the store's single read port and the output register.
// Reset (aresetn, synchronous, active low) clears the byte count, sequencer and output
// valid; the packet store is not cleared, only bytes of the current packet are read.
module time_sync_packet_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic [62:0] s_now_us,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [7:0]  m_seq,
    output logic [63:0] m_value_bits,
    output logic [62:0] m_device_time,
    output logic [7:0]  m_sensor_num,
    output logic [7:0]  m_rate_index,
    output logic [7:0]  m_storage_opts,
    output logic [7:0]  m_name_char,
    output logic        m_last
);
    import tsd_pkg::*;

    logic              accept;
    logic              idle;
    logic              wr_en;
    logic [BUF_AW-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [BUF_AW-1:0] rd_addr;
    logic [7:0]        rd_data;
    pkt_done_t         done;

    // Take a byte transaction only while the sequencer is idle; this is the
    // interlock that keeps writes and readout reads of the store apart.
    assign s_ready = idle;
    assign accept  = s_valid && s_ready;

    // Hunt for the magic byte, store packet bytes, flag completion.
    tsd_framer u_framer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .rx_byte (s_rx_byte),
        .now_us  (s_now_us),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .done    (done)
    );

    // Packet byte memory with registered read data.
    tsd_store u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Read the completed packet back, assemble the record, drive results.
    tsd_readout u_readout (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .done           (done),
        .idle           (idle),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr),
        .rd_data        (rd_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_seq          (m_seq),
        .m_value_bits   (m_value_bits),
        .m_device_time  (m_device_time),
        .m_sensor_num   (m_sensor_num),
        .m_rate_index   (m_rate_index),
        .m_storage_opts (m_storage_opts),
        .m_name_char    (m_name_char),
        .m_last         (m_last)
    );

    // A completed packet must close the input until readout ends.
    a_done_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        done.valid |=> !s_ready)
        else $error("input still open after packet completion");

    // The store is never written and read in the same cycle.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> !wr_en)
        else $error("store write during readout");

    // Every record other than a name character is the last of its transaction.
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_kind != KIND_NAME)) |-> m_last)
        else $error("single record without last flag");

endmodule
